>>> rtl/core/acdb_pkg.sv
// Shared constants, codes and types of the AHCI command descriptor builder.
package acdb_pkg;

    // Sizing of the slot table and the PRDT.
    localparam int MAX_ENTRIES = 32;
    localparam int SLOT_COUNT  = 32;

    // Entry counter wide enough to hold MAX_ENTRIES itself.
    localparam int ENTRY_W = $clog2(MAX_ENTRIES + 1);
    // Slot scan index: holds 0 to SLOT_COUNT, slot mask is always 32 bits.
    localparam int SCAN_W  = 6;

    // Field widths.
    localparam int ACTION_W  = 2;
    localparam int LBA_W     = 48;
    localparam int COUNT_W   = 16;
    localparam int ADDR_W    = 64;
    localparam int MASK_W    = 32;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 5;
    localparam int ECOUNT_W  = 7;
    localparam int OPCODE_W  = 8;
    localparam int BYTES_W   = 13;
    localparam int NENT_W    = 13;

    // Stream payload widths.
    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 168;

    // PRDT geometry.
    localparam logic [ADDR_W-1:0]  ENTRY_STRIDE     = 64'h2000;
    localparam logic [BYTES_W-1:0] FULL_ENTRY_BYTES = 13'h1FFF;
    localparam logic [BYTES_W-1:0] IDENT_BYTES      = 13'd511;

    // Request kinds.
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_IDENT  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRDT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_LEN = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_OP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_OP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT_OP = 2'd2;

    // Reset opcodes.
    localparam logic [OPCODE_W-1:0] RST_READ_OP  = 8'h25;
    localparam logic [OPCODE_W-1:0] RST_WRITE_OP = 8'hCA;
    localparam logic [OPCODE_W-1:0] RST_IDENT_OP = 8'hEC;

    // Result of the slot scan.
    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_scan_res;

    // Control of the PRDT entry unit.
    typedef struct packed {
        logic load;
        logic advance;
    } t_entry_ctl;

endpackage

>>> rtl/core/acdb_slot_scan.sv
// Iterative lowest-free-slot search, one slot tested per cycle.
module acdb_slot_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [acdb_pkg::MASK_W-1:0] i_busy,
    output acdb_pkg::t_scan_res         o_res
);

    logic                        r_busy, n_busy;
    logic [acdb_pkg::MASK_W-1:0] r_mask, n_mask;
    logic [acdb_pkg::SCAN_W-1:0] r_idx, n_idx;
    acdb_pkg::t_scan_res         r_res, n_res;

    always_comb begin
        n_busy = r_busy;
        n_mask = r_mask;
        n_idx  = r_idx;
        n_res  = '0;
        if (i_start) begin
            n_busy = 1'b1;
            n_mask = i_busy;
            n_idx  = '0;
        end else if (r_busy) begin
            if (r_idx == acdb_pkg::SCAN_W'(acdb_pkg::SLOT_COUNT)) begin
                // Every slot in range is taken.
                n_busy      = 1'b0;
                n_res.done  = 1'b1;
            end else if (!r_mask[r_idx[acdb_pkg::SLOT_W-1:0]]) begin
                n_busy      = 1'b0;
                n_res.done  = 1'b1;
                n_res.found = 1'b1;
                n_res.slot  = r_idx[acdb_pkg::SLOT_W-1:0];
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_res  <= '0;
        end else begin
            r_busy <= n_busy;
            r_res  <= n_res;
        end
        r_mask <= n_mask;
        r_idx  <= n_idx;
    end

    assign o_res = r_res;

endmodule

>>> rtl/core/acdb_entry_unit.sv
// PRDT entry walker: shared address adder and remaining-entry counter.
module acdb_entry_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  acdb_pkg::t_entry_ctl         i_ctl,
    input  logic [acdb_pkg::ADDR_W-1:0]  i_addr,
    input  logic [acdb_pkg::ENTRY_W-1:0] i_entries,
    output logic [acdb_pkg::ADDR_W-1:0]  o_addr,
    output logic                         o_last
);

    logic [acdb_pkg::ADDR_W-1:0]  r_addr, n_addr;
    logic [acdb_pkg::ENTRY_W-1:0] r_left, n_left;

    always_comb begin
        n_addr = r_addr;
        n_left = r_left;
        if (i_ctl.load) begin
            n_addr = i_addr;
            n_left = i_entries;
        end else if (i_ctl.advance) begin
            // Address wraps modulo 2^64.
            n_addr = r_addr + acdb_pkg::ENTRY_STRIDE;
            n_left = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
        r_addr <= n_addr;
    end

    assign o_addr = r_addr;
    assign o_last = (r_left == acdb_pkg::ENTRY_W'(1));

endmodule

>>> rtl/core/ahci_command_descriptor_builder.sv
// Top level of the AHCI command descriptor builder: request sequencer and result formatting.
//
// The block takes one disk request per transfer on the slave stream and answers with a
// command item followed by its PRDT entries on the master stream, or with one error item.
// It handles one request at a time and is not ready while a request is in progress. After
// the request transfer, the slot search tests one slot per cycle from slot 0 upwards and
// stops at the lowest free slot or once every slot is found taken. Each result is then
// held until it is taken, one result per cycle while the master side is ready: a full
// read or write thus gives a command item and MAX_ENTRIES entries, and an identify
// request a command item and one entry. The PRDT addresses are produced by one shared
// 64-bit adder that steps by 8 KiB per entry. A request with the unused action code is
// taken and produces no result. Opcodes are configured through the write port; the user
// must write them only while the block is idle, which the block itself does not enforce.
// An index beyond the register list is ignored.
module ahci_command_descriptor_builder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_wr_en,
    input  logic [acdb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [acdb_pkg::OPCODE_W-1:0]    i_cfg_data,
    // Request stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: start_block[47:0], block_count[63:48], buffer_address[127:64],
    //        busy_slots[159:128]
    input  logic [acdb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: action[1:0]
    input  logic [acdb_pkg::ACTION_W-1:0]    s_axis_tuser,
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: status[1:0], slot[6:2], is_write[7], entry_count[14:8], opcode[22:15],
    //        fis_block[70:23], fis_count[86:71], entry_address[150:87],
    //        entry_bytes[163:151], zero fill[167:164]
    output logic [acdb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // tuser: kind[1:0]
    output logic [acdb_pkg::KIND_W-1:0]      m_axis_tuser,
    // tlast: last
    output logic                             m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMD,
        ST_PRDT,
        ST_ERR
    } t_state;

    // Unpacked request fields.
    logic [acdb_pkg::ACTION_W-1:0] in_action;
    logic [acdb_pkg::LBA_W-1:0]    in_lba;
    logic [acdb_pkg::COUNT_W-1:0]  in_count;
    logic [acdb_pkg::ADDR_W-1:0]   in_addr;
    logic [acdb_pkg::MASK_W-1:0]   in_busy;
    logic [acdb_pkg::NENT_W-1:0]   in_entries;

    assign in_lba    = s_axis_tdata[47:0];
    assign in_count  = s_axis_tdata[63:48];
    assign in_addr   = s_axis_tdata[127:64];
    assign in_busy   = s_axis_tdata[159:128];
    assign in_action = s_axis_tuser;
    // One entry per 16 sectors, rounded up.
    assign in_entries = acdb_pkg::NENT_W'((in_count - 1'b1) >> 4) + 1'b1;

    // Configuration registers.
    logic [acdb_pkg::OPCODE_W-1:0] r_read_op, r_write_op, r_ident_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_op  <= acdb_pkg::RST_READ_OP;
            r_write_op <= acdb_pkg::RST_WRITE_OP;
            r_ident_op <= acdb_pkg::RST_IDENT_OP;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                acdb_pkg::CFG_READ_OP:  r_read_op  <= i_cfg_data;
                acdb_pkg::CFG_WRITE_OP: r_write_op <= i_cfg_data;
                acdb_pkg::CFG_IDENT_OP: r_ident_op <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state and held request.
    t_state                         r_state, n_state;
    logic [acdb_pkg::ACTION_W-1:0]  r_action, n_action;
    logic [acdb_pkg::LBA_W-1:0]     r_lba, n_lba;
    logic [acdb_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [acdb_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [acdb_pkg::NENT_W-1:0]    r_entries, n_entries;
    logic                           r_bad_len, n_bad_len;
    // Command item fields and final entry size.
    logic [acdb_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [acdb_pkg::SLOT_W-1:0]    r_slot, n_slot;
    logic                           r_is_write, n_is_write;
    logic [acdb_pkg::ECOUNT_W-1:0]  r_ecount, n_ecount;
    logic [acdb_pkg::OPCODE_W-1:0]  r_opcode, n_opcode;
    logic [acdb_pkg::LBA_W-1:0]     r_fis_block, n_fis_block;
    logic [acdb_pkg::COUNT_W-1:0]   r_fis_count, n_fis_count;
    logic [acdb_pkg::BYTES_W-1:0]   r_last_bytes, n_last_bytes;

    logic                           in_xfer;
    logic                           out_xfer;
    logic                           scan_start;
    acdb_pkg::t_scan_res            scan_res;
    acdb_pkg::t_entry_ctl           entry_ctl;
    logic [acdb_pkg::ENTRY_W-1:0]   entry_load_count;
    logic [acdb_pkg::ADDR_W-1:0]    entry_addr;
    logic                           entry_last;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign scan_start    = in_xfer && (in_action != acdb_pkg::ACT_UNUSED);

    acdb_slot_scan u_slot_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_busy  (in_busy),
        .o_res   (scan_res)
    );

    // Identify always uses a single entry; otherwise the computed count fits the counter
    // whenever the request is accepted for building.
    assign entry_load_count = (r_action == acdb_pkg::ACT_IDENT)
                            ? acdb_pkg::ENTRY_W'(1)
                            : r_entries[acdb_pkg::ENTRY_W-1:0];

    assign entry_ctl.load    = (r_state == ST_SCAN) && scan_res.done && scan_res.found
                             && ((r_action == acdb_pkg::ACT_IDENT) || !r_bad_len);
    assign entry_ctl.advance = (r_state == ST_PRDT) && out_xfer && !entry_last;

    acdb_entry_unit u_entry_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (entry_ctl),
        .i_addr    (r_addr),
        .i_entries (entry_load_count),
        .o_addr    (entry_addr),
        .o_last    (entry_last)
    );

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_lba        = r_lba;
        n_count      = r_count;
        n_addr       = r_addr;
        n_entries    = r_entries;
        n_bad_len    = r_bad_len;
        n_status     = r_status;
        n_slot       = r_slot;
        n_is_write   = r_is_write;
        n_ecount     = r_ecount;
        n_opcode     = r_opcode;
        n_fis_block  = r_fis_block;
        n_fis_count  = r_fis_count;
        n_last_bytes = r_last_bytes;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_action  = in_action;
                    n_lba     = in_lba;
                    n_count   = in_count;
                    n_addr    = in_addr;
                    n_entries = in_entries;
                    n_bad_len = (in_count == '0)
                             || (in_entries > acdb_pkg::NENT_W'(acdb_pkg::MAX_ENTRIES));
                    // The unused action code is dropped without a result.
                    if (in_action != acdb_pkg::ACT_UNUSED) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_res.done) begin
                    n_slot = scan_res.slot;
                    if (!scan_res.found) begin
                        n_status = acdb_pkg::STAT_NO_SLOT;
                        n_state  = ST_ERR;
                    end else if (r_action == acdb_pkg::ACT_IDENT) begin
                        n_is_write   = 1'b0;
                        n_ecount     = acdb_pkg::ECOUNT_W'(1);
                        n_opcode     = r_ident_op;
                        n_fis_block  = '0;
                        n_fis_count  = '0;
                        n_last_bytes = acdb_pkg::IDENT_BYTES;
                        n_state      = ST_CMD;
                    end else if (r_bad_len) begin
                        // Slot availability is checked ahead of the length.
                        n_status = acdb_pkg::STAT_BAD_LEN;
                        n_state  = ST_ERR;
                    end else begin
                        n_is_write   = (r_action == acdb_pkg::ACT_WRITE);
                        n_ecount     = acdb_pkg::ECOUNT_W'(r_entries);
                        n_opcode     = (r_action == acdb_pkg::ACT_WRITE)
                                     ? r_write_op : r_read_op;
                        n_fis_block  = r_lba;
                        n_fis_count  = r_count;
                        // The final entry covers 1 to 16 sectors: byte count minus one.
                        n_last_bytes = {r_count[3:0] - 4'd1, 9'h1FF};
                        n_state      = ST_CMD;
                    end
                end
            end
            ST_CMD: begin
                if (out_xfer) begin
                    n_state = ST_PRDT;
                end
            end
            ST_PRDT: begin
                if (out_xfer && entry_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (out_xfer) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_action     <= n_action;
        r_lba        <= n_lba;
        r_count      <= n_count;
        r_addr       <= n_addr;
        r_entries    <= n_entries;
        r_bad_len    <= n_bad_len;
        r_status     <= n_status;
        r_slot       <= n_slot;
        r_is_write   <= n_is_write;
        r_ecount     <= n_ecount;
        r_opcode     <= n_opcode;
        r_fis_block  <= n_fis_block;
        r_fis_count  <= n_fis_count;
        r_last_bytes <= n_last_bytes;
    end

    // Result formatting: every field is derived from registers alone, and a field that
    // does not belong to the item kind reads as zero.
    logic [acdb_pkg::KIND_W-1:0]    o_kind;
    logic [acdb_pkg::STATUS_W-1:0]  o_status;
    logic [acdb_pkg::SLOT_W-1:0]    o_slot;
    logic                           o_is_write;
    logic [acdb_pkg::ECOUNT_W-1:0]  o_ecount;
    logic [acdb_pkg::OPCODE_W-1:0]  o_opcode;
    logic [acdb_pkg::LBA_W-1:0]     o_fis_block;
    logic [acdb_pkg::COUNT_W-1:0]   o_fis_count;
    logic [acdb_pkg::ADDR_W-1:0]    o_entry_addr;
    logic [acdb_pkg::BYTES_W-1:0]   o_entry_bytes;
    logic                           o_last;

    always_comb begin
        o_kind        = acdb_pkg::KIND_CMD;
        o_status      = acdb_pkg::STAT_OK;
        o_slot        = '0;
        o_is_write    = 1'b0;
        o_ecount      = '0;
        o_opcode      = '0;
        o_fis_block   = '0;
        o_fis_count   = '0;
        o_entry_addr  = '0;
        o_entry_bytes = '0;
        o_last        = 1'b0;
        unique case (r_state)
            ST_CMD: begin
                o_kind      = acdb_pkg::KIND_CMD;
                o_slot      = r_slot;
                o_is_write  = r_is_write;
                o_ecount    = r_ecount;
                o_opcode    = r_opcode;
                o_fis_block = r_fis_block;
                o_fis_count = r_fis_count;
            end
            ST_PRDT: begin
                o_kind        = acdb_pkg::KIND_PRDT;
                o_slot        = r_slot;
                o_entry_addr  = entry_addr;
                o_entry_bytes = entry_last ? r_last_bytes : acdb_pkg::FULL_ENTRY_BYTES;
                o_last        = entry_last;
            end
            ST_ERR: begin
                o_kind   = acdb_pkg::KIND_ERR;
                o_status = r_status;
                o_last   = 1'b1;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = (r_state == ST_CMD) || (r_state == ST_PRDT) || (r_state == ST_ERR);
    assign m_axis_tdata  = {4'b0000, o_entry_bytes, o_entry_addr, o_fis_count, o_fis_block,
                            o_opcode, o_ecount, o_is_write, o_slot, o_status};
    assign m_axis_tuser  = o_kind;
    assign m_axis_tlast  = o_last;

endmodule
